@@ rtl/dchl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchl_pkg
// Shared types and constants of the dynamic line envelope (convex hull trick).
// ----------------------------------------------------------------------------
package dchl_pkg;

    localparam int HULL_DEPTH = 256;
    localparam int ADDR_W     = $clog2(HULL_DEPTH);
    localparam int CNT_W      = $clog2(HULL_DEPTH + 1);

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;
    localparam int X_W     = 32;
    localparam int VAL_W   = 64;

    localparam int MA_W  = SLOPE_W + 1;
    localparam int MB_W  = ICPT_W + 1;
    localparam int MP_W  = MA_W + MB_W;
    localparam int MC_W  = $clog2(MA_W + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                      kind;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic signed [X_W-1:0]     query_x;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
    } t_out;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
    } t_line;

    typedef enum logic [4:0] {
        S_IDLE, S_I_CHK, S_I_BS, S_I_EQ, S_I_NEW, S_SH_CHK, S_SH_WR, S_N_CHK,
        S_P_L, S_P_R, S_LD0, S_LD1, S_LD2, S_LD3, S_U1, S_U1W, S_U2W,
        S_RM_CHK, S_RM_WR, S_Q_CHK, S_Q_RA, S_Q_RB, S_Q_CMP, S_Q_FA, S_Q_FB,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CTX_NEW, CTX_LEFT, CTX_RIGHT
    } t_ctx;

endpackage

@@ rtl/dchl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dchl_ram #(
    parameter int DATA_W = 80,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dchl_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchl_mul
// Bit-serial signed multiplier, one multiplier bit per cycle, for the
// breakpoint cross products.
// ----------------------------------------------------------------------------
module dchl_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [dchl_pkg::MA_W-1:0] i_a,
    input  logic signed [dchl_pkg::MB_W-1:0] i_b,
    output logic                           o_done,
    output logic signed [dchl_pkg::MP_W-1:0] o_prod
);
    import dchl_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [MC_W-1:0]        r_cnt;
    logic [MA_W-1:0]        r_am;
    logic [MB_W-1:0]        r_bm;
    logic                   r_neg;
    logic [MP_W-1:0]        r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MC_W'(MA_W);
                r_am   <= i_a[MA_W-1] ? MA_W'(-i_a) : MA_W'(i_a);
                r_bm   <= i_b[MB_W-1] ? MB_W'(-i_b) : MB_W'(i_b);
                r_neg  <= i_a[MA_W-1] ^ i_b[MB_W-1];
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_acc  <= r_neg ? -r_acc : r_acc;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= (r_acc << 1) + (r_am[MA_W-1] ? MP_W'(r_bm) : '0);
                    r_am  <= r_am << 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_acc);

endmodule

@@ rtl/dynamic_convex_hull_lines.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_convex_hull_lines
// Lower or upper envelope of lines y = m*x + b, kept sorted by slope in RAM.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): kind 0 inserts a line,
// kind 1 evaluates the envelope at query_x. Every transaction gives exactly
// one result on the output channel (o_out_valid / i_out_ready, o_out_data).
// Items are handled one at a time; o_in_ready is high only when the
// sequencer is idle. Results sit in an output register, so a new item is
// taken while the previous result waits for the receiver. A stalled
// receiver holds the result and, once the next item is done, the sequencer.
// Query: a binary search, each step reading two adjacent lines through the
// single RAM read port, then a final read and evaluation. Insert: a binary
// search by slope, a shift or removal of entries, and redundancy tests, each
// using the 33-step serial multiplier twice per test.
// Reset (synchronous, active low) empties the hull and selects min mode.
// A write to i_cfg_we sets the mode from i_cfg_wdata (1 = max) and empties the hull; write only idle.
// ----------------------------------------------------------------------------
module dynamic_convex_hull_lines (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dchl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dchl_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);
    import dchl_pkg::*;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    t_in    r_item, n_item;
    logic   r_mode;
    logic [CNT_W-1:0] r_count, n_count, r_lo, n_lo, r_hi, n_hi;
    logic [CNT_W-1:0] r_pos, n_pos, r_i, n_i;
    t_line  r_la, n_la, r_lb, n_lb, r_lc, n_lc;
    logic signed [VAL_W-1:0] r_prod, n_prod, r_b, n_b, r_va, n_va;
    logic signed [MP_W-1:0]  r_p1, n_p1;
    t_out   r_res, n_res, r_out, n_out;
    logic   r_out_valid, n_out_valid;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_line             ram_wdata, rd_line;
    logic [$bits(t_line)-1:0] ram_rdata;

    logic                     mul_start, mul_done;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   mul_prod;

    logic [CNT_W:0]          sum_lohi, pos_p1, pos_p2, i_p1, cnt_x;
    logic [CNT_W-1:0]        mid;
    logic signed [VAL_W-1:0] rd_prod, vc;
    logic signed [MP_W:0]    cross_sum;
    logic                    useless, better;
    t_line                   new_line;

    dchl_ram #(
        .DATA_W ($bits(t_line)),
        .DEPTH  (HULL_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dchl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign rd_line  = t_line'(ram_rdata);
    assign sum_lohi = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = sum_lohi[CNT_W:1];
    assign pos_p1   = {1'b0, r_pos} + 1'b1;
    assign pos_p2   = {1'b0, r_pos} + 2'd2;
    assign i_p1     = {1'b0, r_i} + 1'b1;
    assign cnt_x    = {1'b0, r_count};
    assign rd_prod  = rd_line.slope * r_item.query_x;
    assign vc       = r_prod + r_b;
    assign cross_sum = (MP_W+1)'(r_p1) + (MP_W+1)'(mul_prod);
    assign useless  = r_mode ? (cross_sum[MP_W] || (cross_sum == '0)) : !cross_sum[MP_W];
    assign better   = r_mode ? (r_item.intercept > rd_line.icpt)
                             : (r_item.intercept < rd_line.icpt);
    assign new_line = '{slope: r_item.slope, icpt: r_item.intercept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_mode      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx  <= n_ctx;
        r_item <= n_item;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_pos  <= n_pos;
        r_i    <= n_i;
        r_la   <= n_la;
        r_lb   <= n_lb;
        r_lc   <= n_lc;
        r_prod <= n_prod;
        r_b    <= n_b;
        r_va   <= n_va;
        r_p1   <= n_p1;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_ctx       = r_ctx;
        n_item      = r_item;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_i         = r_i;
        n_la        = r_la;
        n_lb        = r_lb;
        n_lc        = r_lc;
        n_prod      = r_prod;
        n_b         = r_b;
        n_va        = r_va;
        n_p1        = r_p1;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_i[ADDR_W-1:0];
        ram_wdata   = rd_line;
        ram_re      = 1'b0;
        ram_raddr   = r_i[ADDR_W-1:0];
        mul_start   = 1'b0;
        mul_a       = (MA_W)'(r_lb.slope) - (MA_W)'(r_la.slope);
        mul_b       = (MB_W)'(r_la.icpt) - (MB_W)'(r_lc.icpt);
        o_in_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_lo   = '0;
                    if (i_in_data.kind == KIND_QUERY) begin
                        n_hi = r_count - 1'b1;
                        if (r_count == '0) begin
                            n_res   = '{value: '0, status: ST_EMPTY};
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_Q_CHK;
                        end
                    end else begin
                        n_hi    = r_count;
                        n_state = S_I_CHK;
                    end
                end
            end
            S_I_CHK: begin
                if (r_lo < r_hi) begin
                    n_i       = mid;
                    ram_re    = 1'b1;
                    ram_raddr = mid[ADDR_W-1:0];
                    n_state   = S_I_BS;
                end else begin
                    n_pos = r_lo;
                    if (r_lo < r_count) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_lo[ADDR_W-1:0];
                        n_state   = S_I_EQ;
                    end else begin
                        n_state = S_I_NEW;
                    end
                end
            end
            S_I_BS: begin
                if (rd_line.slope < r_item.slope) begin
                    n_lo = r_i + 1'b1;
                end else begin
                    n_hi = r_i;
                end
                n_state = S_I_CHK;
            end
            S_I_EQ: begin
                if (rd_line.slope == r_item.slope) begin
                    if (!better) begin
                        n_res   = '{value: '0, status: ST_DROP};
                        n_state = S_EMIT;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pos[ADDR_W-1:0];
                        ram_wdata = new_line;
                        n_state   = S_P_L;
                    end
                end else begin
                    n_state = S_I_NEW;
                end
            end
            S_I_NEW: begin
                if (r_count == CNT_W'(HULL_DEPTH)) begin
                    n_res   = '{value: '0, status: ST_FULL};
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_count;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                if (r_i > r_pos) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_i - 1'b1);
                    n_state   = S_SH_WR;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[ADDR_W-1:0];
                    ram_wdata = new_line;
                    n_count   = r_count + 1'b1;
                    n_state   = S_N_CHK;
                end
            end
            S_SH_WR: begin
                ram_we  = 1'b1;
                n_i     = r_i - 1'b1;
                n_state = S_SH_CHK;
            end
            S_N_CHK: begin
                if (r_pos != '0 && pos_p1 < cnt_x) begin
                    n_i     = r_pos - 1'b1;
                    n_ctx   = CTX_NEW;
                    n_state = S_LD0;
                end else begin
                    n_state = S_P_L;
                end
            end
            S_P_L: begin
                if (r_pos >= CNT_W'(2)) begin
                    n_i     = r_pos - CNT_W'(2);
                    n_ctx   = CTX_LEFT;
                    n_state = S_LD0;
                end else begin
                    n_state = S_P_R;
                end
            end
            S_P_R: begin
                if (pos_p2 < cnt_x) begin
                    n_i     = r_pos;
                    n_ctx   = CTX_RIGHT;
                    n_state = S_LD0;
                end else begin
                    n_res   = '{value: '0, status: ST_OK};
                    n_state = S_EMIT;
                end
            end
            S_LD0: begin
                ram_re  = 1'b1;
                n_state = S_LD1;
            end
            S_LD1: begin
                n_la      = rd_line;
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(r_i + 1'b1);
                n_state   = S_LD2;
            end
            S_LD2: begin
                n_lb      = rd_line;
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(r_i + CNT_W'(2));
                n_state   = S_LD3;
            end
            S_LD3: begin
                n_lc    = rd_line;
                n_state = S_U1;
            end
            S_U1: begin
                mul_start = 1'b1;
                n_state   = S_U1W;
            end
            S_U1W: begin
                mul_a = (MA_W)'(r_lc.slope) - (MA_W)'(r_la.slope);
                mul_b = (MB_W)'(r_lb.icpt) - (MB_W)'(r_la.icpt);
                if (mul_done) begin
                    n_p1      = mul_prod;
                    mul_start = 1'b1;
                    n_state   = S_U2W;
                end
            end
            S_U2W: begin
                if (mul_done) begin
                    unique case (r_ctx)
                        CTX_NEW: begin
                            if (useless) begin
                                n_i     = r_pos;
                                n_state = S_RM_CHK;
                            end else begin
                                n_state = S_P_L;
                            end
                        end
                        CTX_LEFT: begin
                            if (useless) begin
                                n_i     = r_pos - 1'b1;
                                n_pos   = r_pos - 1'b1;
                                n_state = S_RM_CHK;
                            end else begin
                                n_state = S_P_R;
                            end
                        end
                        default: begin
                            if (useless) begin
                                n_i     = r_pos + 1'b1;
                                n_state = S_RM_CHK;
                            end else begin
                                n_res   = '{value: '0, status: ST_OK};
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_RM_CHK: begin
                if (i_p1 < cnt_x) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_i + 1'b1);
                    n_state   = S_RM_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    unique case (r_ctx)
                        CTX_NEW: begin
                            n_res   = '{value: '0, status: ST_DROP};
                            n_state = S_EMIT;
                        end
                        CTX_LEFT: n_state = S_P_L;
                        default:  n_state = S_P_R;
                    endcase
                end
            end
            S_RM_WR: begin
                ram_we  = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_RM_CHK;
            end
            S_Q_CHK: begin
                ram_re = 1'b1;
                if (r_lo < r_hi) begin
                    n_i       = mid;
                    ram_raddr = mid[ADDR_W-1:0];
                    n_state   = S_Q_RA;
                end else begin
                    ram_raddr = r_lo[ADDR_W-1:0];
                    n_state   = S_Q_FA;
                end
            end
            S_Q_RA: begin
                n_prod    = rd_prod;
                n_b       = VAL_W'(rd_line.icpt);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(r_i + 1'b1);
                n_state   = S_Q_RB;
            end
            S_Q_RB: begin
                n_va    = vc;
                n_prod  = rd_prod;
                n_b     = VAL_W'(rd_line.icpt);
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (r_mode ? (r_va >= vc) : (r_va <= vc)) begin
                    n_hi = r_i;
                end else begin
                    n_lo = r_i + 1'b1;
                end
                n_state = S_Q_CHK;
            end
            S_Q_FA: begin
                n_prod  = rd_prod;
                n_b     = VAL_W'(rd_line.icpt);
                n_state = S_Q_FB;
            end
            S_Q_FB: begin
                n_res   = '{value: vc, status: ST_OK};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            n_count = '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/dchl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchl_checker
// Port-level checks of the line envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module dchl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dchl_pkg::t_out o_out_data
);
    import dchl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new transaction taken while one is in progress");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_EMPTY || o_out_data.status == ST_DROP
                         || o_out_data.status == ST_FULL)) |-> (o_out_data.value == '0))
        else $error("flagged result carries a nonzero value");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output not empty after reset");

endmodule

bind dynamic_convex_hull_lines dchl_checker u_dchl_checker (.*);

@@ tb/sv/dynamic_convex_hull_lines_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_convex_hull_lines_tb
// Self-checking bench for the line envelope: drives inserts and queries under
// random idling and stalls, predicts every result with a behavioral envelope
// kept in arrays of lines, and compares value and status of each transaction.
// ----------------------------------------------------------------------------
module dynamic_convex_hull_lines_tb;
    import dchl_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    dynamic_convex_hull_lines DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // envelope predictor state
    longint env_m[HULL_DEPTH];
    longint env_b[HULL_DEPTH];
    int     env_count = 0;
    bit     env_max = 1'b0;

    t_out   expected_results[$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     idle_cycles = 0;

    function automatic bit redundant(int i, int j, int k);
        logic signed [127:0] a, b, c, d, s;
        a = env_m[j] - env_m[i];
        b = env_b[i] - env_b[k];
        c = env_b[j] - env_b[i];
        d = env_m[k] - env_m[i];
        s = a * b + c * d;
        return env_max ? (s <= 0) : (s >= 0);
    endfunction

    function automatic void drop_line(int p);
        for (int i = p; i + 1 < env_count; i++) begin
            env_m[i] = env_m[i + 1];
            env_b[i] = env_b[i + 1];
        end
        env_count--;
    endfunction

    function automatic void trim_around(int p);
        int pos;
        pos = p;
        while (pos >= 2 && redundant(pos - 2, pos - 1, pos)) begin
            drop_line(pos - 1);
            pos--;
        end
        while (pos + 2 < env_count && redundant(pos, pos + 1, pos + 2))
            drop_line(pos + 1);
    endfunction

    function automatic logic [1:0] place_line(longint m, longint b);
        int lo, hi, md;
        lo = 0;
        hi = env_count;
        while (lo < hi) begin
            md = (lo + hi) / 2;
            if (env_m[md] < m) lo = md + 1; else hi = md;
        end
        if (lo < env_count && env_m[lo] == m) begin
            if (!(env_max ? (b > env_b[lo]) : (b < env_b[lo]))) return ST_DROP;
            env_b[lo] = b;
            trim_around(lo);
            return ST_OK;
        end
        if (env_count >= HULL_DEPTH) return ST_FULL;
        for (int i = env_count; i > lo; i--) begin
            env_m[i] = env_m[i - 1];
            env_b[i] = env_b[i - 1];
        end
        env_m[lo] = m;
        env_b[lo] = b;
        env_count++;
        if (lo >= 1 && lo + 1 < env_count && redundant(lo - 1, lo, lo + 1)) begin
            drop_line(lo);
            return ST_DROP;
        end
        trim_around(lo);
        return ST_OK;
    endfunction

    function automatic t_out envelope_result(t_in item);
        t_out r;
        int lo, hi, md;
        longint x, ya, yc;
        r = '0;
        if (item.kind == KIND_INSERT) begin
            r.status = place_line(longint'(item.slope), longint'(item.intercept));
        end else if (env_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            x = longint'(item.query_x);
            lo = 0;
            hi = env_count - 1;
            while (lo < hi) begin
                md = (lo + hi) / 2;
                ya = env_m[md] * x + env_b[md];
                yc = env_m[md + 1] * x + env_b[md + 1];
                if (env_max ? (ya >= yc) : (ya <= yc)) hi = md; else lo = md + 1;
            end
            r.value = env_m[lo] * x + env_b[lo];
            r.status = ST_OK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.value !== want.value || o_out_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %0d status %0d, got value %0d status %0d",
                                 want.value, want.status, o_out_data.value,
                                 o_out_data.status);
                end
            end
        end
    end

    task automatic send_item(t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(envelope_result(item));
    endtask

    task automatic send_line(longint m, longint b);
        t_in item;
        item.kind = KIND_INSERT;
        item.slope = m[SLOPE_W-1:0];
        item.intercept = b[ICPT_W-1:0];
        item.query_x = $urandom;
        send_item(item);
    endtask

    task automatic send_query(longint x);
        t_in item;
        item.kind = KIND_QUERY;
        item.slope = $urandom;
        item.intercept = ICPT_W'({$urandom, $urandom});
        item.query_x = x[X_W-1:0];
        send_item(item);
    endtask

    task automatic set_mode(bit mode);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        env_max = mode;
        env_count = 0;
    endtask

    task automatic test_directed(bit mode);
        longint sgn;
        set_mode(mode);
        sgn = mode ? -1 : 1;
        send_query(0);
        send_line(-1, 0);
        send_line(1, 0);
        send_line(0, 5 * sgn);
        send_line(1, 3 * sgn);
        send_line(1, -2 * sgn);
        send_line(1, -2 * sgn);
        send_query(0);
        send_query(64'sd2147483647);
        send_query(-64'sd2147483648);
        send_line(64'sd2147483647, 64'sd140737488355327);
        send_line(-64'sd2147483648, -64'sd140737488355328);
        send_line(64'sd2147483647, -64'sd140737488355328);
        send_line(-64'sd2147483648, 64'sd140737488355327);
        send_query(64'sd2147483647);
        send_query(-64'sd2147483648);
        send_query(-1);
        send_query(1);
    endtask

    task automatic test_store_full(bit mode);
        set_mode(mode);
        for (int k = 0; k <= HULL_DEPTH; k++)
            send_line(k - 128, mode ? -(k - 128) * (k - 128) : (k - 128) * (k - 128));
        send_line(-128, mode ? -20000 : 20000);
        send_query(100);
        send_query(-300);
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct, bit mode);
        longint m, b, x;
        logic [ICPT_W-1:0] b_raw;
        set_mode(mode);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(99) < 75) begin
                    m = longint'($urandom_range(60)) - 30;
                    b = longint'($urandom_range(4000)) - 2000;
                end else begin
                    m = longint'(signed'($urandom));
                    b_raw = {16'($urandom_range(65535)), $urandom};
                    b = longint'(signed'(b_raw));
                end
                send_line(m, b);
            end else begin
                if ($urandom_range(99) < 60) x = longint'($urandom_range(400)) - 200;
                else x = longint'(signed'($urandom));
                send_query(x);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed(1'b0);
        test_directed(1'b1);
        test_store_full(1'b0);
        test_store_full(1'b1);
        test_random(100, 0, 0, 1'b0);
        test_random(100, 65, 0, 1'b1);
        test_random(100, 0, 65, 1'b0);
        test_random(100, 21, 21, 1'b1);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
